[rtl/hls_pkg.sv]
// shared types, constants and helpers for the header line splitter
package hls_pkg;

  localparam int NAME_MAX_DEF   = 32;
  localparam int RETURN_MAX_DEF = 8;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } hls_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_value;
    logic       field_done;
    logic       key_overflow;
    logic       last;
  } hls_out_t;

  // line parse mode
  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_NAME    = 3'd1,
    MODE_SKIP    = 3'd2,
    MODE_VALUE   = 3'd3,
    MODE_DISCARD = 3'd4
  } hls_mode_t;

  // sequencer state
  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_DUMP = 2'd1,
    SEQ_RETS = 2'd2
  } hls_seq_t;

  // source of the next result
  typedef enum logic [2:0] {
    OSEL_DONE   = 3'd0,
    OSEL_OVF    = 3'd1,
    OSEL_INBYTE = 3'd2,
    OSEL_NAME   = 3'd3,
    OSEL_CR     = 3'd4,
    OSEL_HELD   = 3'd5
  } hls_osel_t;

  typedef struct packed {
    logic      name_first;
    logic      name_append;
    logic      len_clear;
    logic      ret_inc;
    logic      ret_dec;
    logic      ret_clear;
    logic      idx_clear;
    logic      idx_inc;
    logic      hold_byte;
    logic      out_load;
    logic      out_last;
    hls_osel_t out_sel;
  } hls_cmd_t;

  typedef struct packed {
    logic line_end;
    logic is_colon;
    logic is_cr;
    logic is_print;
    logic len_full;
    logic ret_zero;
    logic ret_full;
    logic idx_last;
    logic out_free;
  } hls_sts_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[rtl/hls_dp.sv]
// datapath: name memory, length and return counters, output register
module hls_dp import hls_pkg::*; #(
  parameter int NAME_MAX   = NAME_MAX_DEF,
  parameter int RETURN_MAX = RETURN_MAX_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  hls_in_t  in_data,
  input  logic     out_stall,
  input  hls_cmd_t cmd,
  output hls_sts_t sts,
  output logic     out_valid,
  output hls_out_t out_data
);

  localparam int LW = $clog2(NAME_MAX + 1);
  localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int RW = $clog2(RETURN_MAX + 1);

  logic [7:0]    name_mem [NAME_MAX];
  logic [7:0]    rd_data_r;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [RW-1:0] ret_r, ret_nxt;
  logic [7:0]    held_r;
  logic          out_valid_r, out_valid_nxt;
  hls_out_t      out_data_r, out_data_nxt;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;

  assign sts.line_end = in_data.end_of_input || (in_data.in_byte == CHAR_LF);
  assign sts.is_colon = in_data.in_byte == CHAR_COLON;
  assign sts.is_cr    = in_data.in_byte == CHAR_CR;
  assign sts.is_print = in_data.in_byte > CHAR_SPACE;
  assign sts.len_full = len_r == LW'(NAME_MAX);
  assign sts.ret_zero = ret_r == '0;
  assign sts.ret_full = ret_r == RW'(RETURN_MAX);
  assign sts.idx_last = idx_r == (len_r - LW'(1));
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    len_nxt = len_r;
    if (cmd.len_clear) begin
      len_nxt = '0;
    end else if (cmd.name_first) begin
      len_nxt = LW'(1);
    end else if (cmd.name_append) begin
      len_nxt = len_r + LW'(1);
    end
  end

  always_comb begin
    ret_nxt = ret_r;
    if (cmd.ret_clear) begin
      ret_nxt = '0;
    end else if (cmd.ret_inc) begin
      ret_nxt = ret_r + RW'(1);
    end else if (cmd.ret_dec) begin
      ret_nxt = ret_r - RW'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clear) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + LW'(1);
    end
  end

  // the read port follows the next index, so rd_data_r matches idx_r
  assign rd_addr = (idx_nxt < LW'(NAME_MAX)) ? idx_nxt[AW-1:0] : '0;
  assign wr_en   = cmd.name_first || cmd.name_append;
  assign wr_addr = cmd.name_first ? '0 : len_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      name_mem[wr_addr] <= in_data.in_byte;
    end
    rd_data_r <= name_mem[rd_addr];
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt.last = cmd.out_last;
    case (cmd.out_sel)
      OSEL_DONE: begin
        out_data_nxt.field_done = 1'b1;
      end
      OSEL_OVF: begin
        out_data_nxt.key_overflow = 1'b1;
      end
      OSEL_INBYTE: begin
        out_data_nxt.out_byte   = in_data.in_byte;
        out_data_nxt.byte_valid = 1'b1;
        out_data_nxt.is_value   = 1'b1;
      end
      OSEL_NAME: begin
        out_data_nxt.out_byte   = to_lower(rd_data_r);
        out_data_nxt.byte_valid = 1'b1;
      end
      OSEL_CR: begin
        out_data_nxt.out_byte   = CHAR_CR;
        out_data_nxt.byte_valid = 1'b1;
        out_data_nxt.is_value   = 1'b1;
      end
      OSEL_HELD: begin
        out_data_nxt.out_byte   = held_r;
        out_data_nxt.byte_valid = 1'b1;
        out_data_nxt.is_value   = 1'b1;
      end
      default: begin
        out_data_nxt.field_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      idx_r       <= '0;
      ret_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
    if (cmd.hold_byte) begin
      held_r <= in_data.in_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/hls_ctrl.sv]
// controller: line parse mode and result sequencer
module hls_ctrl import hls_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hls_sts_t sts,
  output hls_cmd_t cmd
);

  hls_seq_t  seq_r, seq_nxt;
  hls_mode_t mode_r, mode_nxt;
  logic      accept;

  assign accept   = (seq_r == SEQ_IDLE) && in_valid && sts.out_free;
  assign in_stall = !((seq_r == SEQ_IDLE) && sts.out_free);

  // next state
  always_comb begin
    seq_nxt  = seq_r;
    mode_nxt = mode_r;
    case (seq_r)
      SEQ_IDLE: begin
        if (accept) begin
          if (sts.line_end) begin
            mode_nxt = MODE_START;
          end else begin
            case (mode_r)
              MODE_NAME: begin
                if (sts.is_colon) begin
                  mode_nxt = MODE_SKIP;
                  seq_nxt  = SEQ_DUMP;
                end else if (sts.len_full) begin
                  mode_nxt = MODE_DISCARD;
                end
              end
              MODE_SKIP: begin
                if (sts.is_print) begin
                  mode_nxt = MODE_VALUE;
                end
              end
              MODE_VALUE: begin
                if (!sts.is_cr && !sts.ret_zero) begin
                  seq_nxt = SEQ_RETS;
                end
              end
              MODE_DISCARD: begin
                mode_nxt = MODE_DISCARD;
              end
              default: begin
                if (sts.is_print) begin
                  mode_nxt = sts.is_colon ? MODE_DISCARD : MODE_NAME;
                end
              end
            endcase
          end
        end
      end
      SEQ_DUMP: begin
        if (sts.out_free && sts.idx_last) begin
          seq_nxt = SEQ_IDLE;
        end
      end
      SEQ_RETS: begin
        if (sts.out_free && sts.ret_zero) begin
          seq_nxt = SEQ_IDLE;
        end
      end
      default: begin
        seq_nxt = SEQ_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (seq_r)
      SEQ_IDLE: begin
        if (accept) begin
          if (sts.line_end) begin
            if (mode_r == MODE_SKIP || mode_r == MODE_VALUE) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              cmd.out_sel  = OSEL_DONE;
            end
            cmd.len_clear = 1'b1;
            cmd.ret_clear = 1'b1;
          end else begin
            case (mode_r)
              MODE_NAME: begin
                if (sts.is_colon) begin
                  cmd.idx_clear = 1'b1;
                  cmd.ret_clear = 1'b1;
                end else if (sts.len_full) begin
                  cmd.out_load = 1'b1;
                  cmd.out_last = 1'b1;
                  cmd.out_sel  = OSEL_OVF;
                end else begin
                  cmd.name_append = 1'b1;
                end
              end
              MODE_SKIP: begin
                if (sts.is_print) begin
                  cmd.out_load = 1'b1;
                  cmd.out_last = 1'b1;
                  cmd.out_sel  = OSEL_INBYTE;
                end
              end
              MODE_VALUE: begin
                if (sts.is_cr) begin
                  cmd.ret_inc = !sts.ret_full;
                end else if (sts.ret_zero) begin
                  cmd.out_load = 1'b1;
                  cmd.out_last = 1'b1;
                  cmd.out_sel  = OSEL_INBYTE;
                end else begin
                  cmd.hold_byte = 1'b1;
                end
              end
              MODE_DISCARD: begin
                cmd = '0;
              end
              default: begin
                cmd.name_first = sts.is_print && !sts.is_colon;
              end
            endcase
          end
        end
      end
      SEQ_DUMP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = sts.idx_last;
          cmd.out_sel  = OSEL_NAME;
          cmd.idx_inc  = 1'b1;
        end
      end
      SEQ_RETS: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.ret_zero) begin
            cmd.out_last = 1'b1;
            cmd.out_sel  = OSEL_HELD;
          end else begin
            cmd.out_sel = OSEL_CR;
            cmd.ret_dec = 1'b1;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= SEQ_IDLE;
      mode_r <= MODE_START;
    end else begin
      seq_r  <= seq_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

[rtl/header_line_splitter_top.sv]
// top level of the header line splitter
//
// in channel: one header byte (or an end-of-input mark) per request, valid/stall.
// out channel: each result is a name byte (lowercased), a value byte,
// a field_done marker or a key_overflow marker; last flags the final result
// caused by an input request. Requests that cause nothing give no result.
// A single result sits in the output register the cycle after the request that
// causes it; a name dump or a run of held returns is sent from the sequencer
// state entered after it. One request per cycle is taken while each causes at
// most one result and the output is free. A colon ending a name stalls the input
// while the buffered name bytes (up to NAME_MAX) are read out, one a cycle when
// the output is free; a value byte after held returns stalls it until all are out.
// The input is also stalled whenever the output register is full and stalled,
// so a stalling receiver backs up to the sender with no loss.
// Reset (rst_n low, synchronous) empties the output register and returns the
// parser to line start; the name buffer needs no clearing.
module header_line_splitter_top import hls_pkg::*; #(
  parameter int NAME_MAX   = NAME_MAX_DEF,
  parameter int RETURN_MAX = RETURN_MAX_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hls_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hls_out_t out_data
);

  hls_cmd_t cmd;
  hls_sts_t sts;

  hls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hls_dp #(
    .NAME_MAX   (NAME_MAX),
    .RETURN_MAX (RETURN_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // no new request while a result is stuck in the output register
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("request taken while output register blocked");

  a_done_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.field_done || out_data.key_overflow)) |->
      (!out_data.byte_valid && out_data.last))
    else $error("marker result carries a byte or is not last");

  // a request accepted with the output free either yields its result or nothing
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (!out_valid || out_data.last ||
      (out_data.byte_valid && !out_data.field_done)))
    else $error("unexpected result after request");

endmodule

[sim/header_line_splitter_checker.sv]
// checker for the header line splitter: predicts each result from the accepted requests
`timescale 1ns / 100ps

module header_line_splitter_checker import hls_pkg::*; #(
  parameter int NAME_MAX   = NAME_MAX_DEF,
  parameter int RETURN_MAX = RETURN_MAX_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  hls_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  hls_out_t out_data,
  output int       fail_count,
  output int       results_pending
);

  hls_out_t   results_due[$];
  hls_mode_t  line_mode;
  logic [7:0] name_buf [NAME_MAX];
  int         name_len;
  int         cr_held;
  int         mismatches;
  int         result_num;

  task automatic report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [7:0] name_fold(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic hls_out_t make_result(logic [7:0] b, logic bv, logic val, logic done,
                                           logic ovf);
    hls_out_t r;
    r.out_byte     = b;
    r.byte_valid   = bv;
    r.is_value     = val;
    r.field_done   = done;
    r.key_overflow = ovf;
    r.last         = 1'b0;
    return r;
  endfunction

  // works out the results that one accepted request causes
  task automatic parse_request(hls_in_t req);
    hls_out_t   step_out[$];
    hls_out_t   r;
    logic [7:0] c;
    c = req.in_byte;
    if (req.end_of_input || c == CHAR_LF) begin
      if (line_mode == MODE_SKIP || line_mode == MODE_VALUE) begin
        step_out.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
      end
      line_mode = MODE_START;
      name_len  = 0;
      cr_held   = 0;
    end else begin
      case (line_mode)
        MODE_NAME: begin
          if (c == CHAR_COLON) begin
            for (int i = 0; i < name_len; i++) begin
              step_out.push_back(make_result(name_fold(name_buf[i]), 1'b1, 1'b0, 1'b0, 1'b0));
            end
            line_mode = MODE_SKIP;
            cr_held   = 0;
          end else if (name_len >= NAME_MAX) begin
            step_out.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
            line_mode = MODE_DISCARD;
          end else begin
            name_buf[name_len] = c;
            name_len++;
          end
        end
        MODE_SKIP: begin
          if (c > CHAR_SPACE) begin
            step_out.push_back(make_result(c, 1'b1, 1'b1, 1'b0, 1'b0));
            line_mode = MODE_VALUE;
          end
        end
        MODE_VALUE: begin
          if (c == CHAR_CR) begin
            // extra returns past the limit are lost
            if (cr_held < RETURN_MAX) begin
              cr_held++;
            end
          end else begin
            repeat (cr_held) step_out.push_back(make_result(CHAR_CR, 1'b1, 1'b1, 1'b0, 1'b0));
            cr_held = 0;
            step_out.push_back(make_result(c, 1'b1, 1'b1, 1'b0, 1'b0));
          end
        end
        MODE_DISCARD: begin
        end
        default: begin
          if (c > CHAR_SPACE) begin
            if (c == CHAR_COLON) begin
              line_mode = MODE_DISCARD;
            end else begin
              name_buf[0] = c;
              name_len    = 1;
              line_mode   = MODE_NAME;
            end
          end
        end
      endcase
    end
    if (step_out.size() > 0) begin
      r = step_out[step_out.size() - 1];
      r.last = 1'b1;
      step_out[step_out.size() - 1] = r;
    end
    foreach (step_out[i]) begin
      results_due.push_back(step_out[i]);
    end
  endtask

  task automatic compare_field(string fname, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report($sformatf("result %0d %s got %0h expected %0h", result_num, fname, got, want));
    end
  endtask

  task automatic check_result(hls_out_t got);
    hls_out_t want;
    if (results_due.size() == 0) begin
      report($sformatf("result %0d arrived with nothing pending", result_num));
    end else begin
      want = results_due.pop_front();
      compare_field("out_byte", got.out_byte, want.out_byte);
      compare_field("byte_valid", got.byte_valid, want.byte_valid);
      compare_field("is_value", got.is_value, want.is_value);
      compare_field("field_done", got.field_done, want.field_done);
      compare_field("key_overflow", got.key_overflow, want.key_overflow);
      compare_field("last", got.last, want.last);
    end
    result_num++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      results_due.delete();
      line_mode = MODE_START;
      name_len  = 0;
      cr_held   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_request(in_data);
      end
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
    end
    fail_count      <= mismatches;
    results_pending <= results_due.size();
  end

endmodule

[sim/header_line_splitter_top_tb.sv]
// testbench top for the header line splitter: clock, reset, request traffic and verdict
`timescale 1ns / 100ps

module header_line_splitter_top_tb import hls_pkg::*;;

  localparam int QUIET_LIMIT = 400;
  localparam int REQUEST_GOAL = 400;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  hls_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hls_out_t out_data;

  int fail_count;
  int results_pending;
  int requests_sent;
  int quiet_cycles;
  int in_calm;
  int out_calm;

  header_line_splitter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  header_line_splitter_checker split_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  always #4 clk = ~clk;

  task automatic send_request(logic [7:0] b, logic eoi);
    int gap;
    if (in_calm > 0) begin
      in_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) begin
        in_calm = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, end_of_input: eoi};
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_request(s[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] letter();
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
  endfunction

  // mostly well-formed header lines with random content, some noise
  task automatic send_random_line();
    int         kind;
    int         name_n;
    logic [7:0] c;
    kind = $urandom_range(0, 19);
    if (kind == 13 || kind == 14) begin
      repeat ($urandom_range(1, 6)) send_request(8'($urandom_range(0, 255)),
                                                 $urandom_range(0, 9) == 0);
      send_request(CHAR_LF, 1'b0);
    end else if (kind == 15) begin
      // line opening with a colon
      send_request(CHAR_COLON, 1'b0);
      repeat ($urandom_range(0, 3)) send_request(8'($urandom_range(0, 255)), 1'b0);
      send_request(CHAR_LF, 1'b0);
    end else if (kind == 16) begin
      // name with no colon
      repeat ($urandom_range(1, 5)) send_request(letter(), 1'b0);
      send_request($urandom_range(0, 1) ? CHAR_LF : 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
    end else if (kind == 17) begin
      send_request(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      repeat ($urandom_range(0, 2)) send_request(8'($urandom_range(0, 32)), 1'b0);
      name_n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
      send_request(letter(), 1'b0);
      repeat (name_n - 1) begin
        case ($urandom_range(0, 3))
          0, 1: c = letter();
          2: c = 8'h2d;
          default: do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON || c == CHAR_LF);
        endcase
        send_request(c, 1'b0);
      end
      send_request(CHAR_COLON, 1'b0);
      repeat ($urandom_range(0, 3)) send_request($urandom_range(0, 1) ? CHAR_SPACE : 8'h09,
                                                 1'b0);
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 12)) send_request(CHAR_CR, 1'b0);
        end
        if ($urandom_range(0, 3) == 0) begin
          do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
        end else begin
          c = 8'($urandom_range(33, 126));
        end
        send_request(c, 1'b0);
      end
      case ($urandom_range(0, 3))
        0: send_request(CHAR_LF, 1'b0);
        1: send_request(8'($urandom_range(0, 255)), 1'b1);
        default: begin
          send_request(CHAR_CR, 1'b0);
          send_request(CHAR_LF, 1'b0);
        end
      endcase
    end
  endtask

  initial begin
    int hold;
    forever begin
      if (out_calm > 0) begin
        out_calm--;
        hold = 0;
      end else begin
        hold = $urandom_range(0, 8);
        if ($urandom_range(0, 15) == 0) begin
          out_calm = $urandom_range(10, 40);
        end
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // blanks and control bytes at line start are skipped
    send_request(8'h00, 1'b0);
    send_request(CHAR_SPACE, 1'b0);
    send_text("Az:\t ");
    send_request(8'hff, 1'b0);
    // held return released by a later byte, trailing returns dropped
    send_text("\rv\r\r\n");
    send_text(":x\n");
    send_text("Q\n");
    // empty value closed by end of input
    send_text("K: ");
    send_request(8'hff, 1'b1);
    send_request(8'h00, 1'b1);
    send_text("m:w");
    send_request(8'h5a, 1'b1);

    while (requests_sent < REQUEST_GOAL) begin
      send_random_line();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
